// ===== src/nct_pkg.sv =====
package nct_pkg;

  // field widths and limits
  localparam int NumW      = 31;
  localparam int CharW     = 16;
  localparam int DigitsMax = 10;

  // style register codes
  localparam logic [2:0] STYLE_DEC      = 3'd0;
  localparam logic [2:0] STYLE_ALPHA_LO = 3'd1;
  localparam logic [2:0] STYLE_ALPHA_UP = 3'd2;
  localparam logic [2:0] STYLE_ROMAN_LO = 3'd3;
  localparam logic [2:0] STYLE_ROMAN_UP = 3'd4;

  // configuration register indexes
  localparam logic [1:0] CFG_STYLE      = 2'd0;
  localparam logic [1:0] CFG_MIN_LENGTH = 2'd1;
  localparam logic [1:0] CFG_GROUP_SIZE = 2'd2;
  localparam logic [1:0] CFG_GROUP_SEP  = 2'd3;

  // reciprocal constants for division by ten and by twenty-six
  localparam logic [31:0] RECIP10 = 32'hCCCC_CCCD;
  localparam logic [31:0] RECIP26 = 32'h9D89_D89E;

  localparam logic [NumW-1:0] ROMAN_LIMIT = 31'd4000;

  // roman symbol kinds
  localparam logic [1:0] SYM_ONE  = 2'd0;
  localparam logic [1:0] SYM_FIVE = 2'd1;
  localparam logic [1:0] SYM_TEN  = 2'd2;

  typedef enum logic [1:0] {
    MODE_DEC,
    MODE_ALPHA,
    MODE_ROMAN
  } mode_e;

  typedef logic [4:0] digit_t;

  // one converted number, least significant digit first
  typedef struct packed {
    mode_e                        mode;
    logic                         upper;
    digit_t [DigitsMax-1:0]       dig;
    logic [3:0]                   ndig;
    logic [5:0]                   total;
    logic [5:0]                   phase;
    logic [5:0]                   group;
    logic [CharW-1:0]             sep;
  } job_t;

  // number of roman letters for one decimal digit
  function automatic logic [2:0] shape_len(input logic [3:0] d);
    logic [2:0] len;
    case (d)
      4'd1:    len = 3'd1;
      4'd2:    len = 3'd2;
      4'd3:    len = 3'd3;
      4'd4:    len = 3'd2;
      4'd5:    len = 3'd1;
      4'd6:    len = 3'd2;
      4'd7:    len = 3'd3;
      4'd8:    len = 3'd4;
      4'd9:    len = 3'd2;
      default: len = 3'd0;
    endcase
    return len;
  endfunction

  // symbol kind at place k of the shape of digit d
  function automatic logic [1:0] shape_sym(input logic [3:0] d, input logic [1:0] k);
    logic [1:0] s;
    case (d)
      4'd4:             s = (k == 2'd0) ? SYM_ONE : SYM_FIVE;
      4'd5:             s = SYM_FIVE;
      4'd6, 4'd7, 4'd8: s = (k == 2'd0) ? SYM_FIVE : SYM_ONE;
      4'd9:             s = (k == 2'd0) ? SYM_ONE : SYM_TEN;
      default:          s = SYM_ONE;
    endcase
    return s;
  endfunction

  // lower case roman letter; p is 2 for hundreds, 1 for tens, 0 for units
  function automatic logic [7:0] roman_char(input logic [1:0] p, input logic [1:0] s);
    logic [7:0] c;
    case ({p, s})
      {2'd2, SYM_ONE}:  c = 8'h63;
      {2'd2, SYM_FIVE}: c = 8'h64;
      {2'd2, SYM_TEN}:  c = 8'h6D;
      {2'd1, SYM_ONE}:  c = 8'h78;
      {2'd1, SYM_FIVE}: c = 8'h6C;
      {2'd1, SYM_TEN}:  c = 8'h63;
      {2'd0, SYM_FIVE}: c = 8'h76;
      {2'd0, SYM_TEN}:  c = 8'h78;
      default:          c = 8'h69;
    endcase
    return c;
  endfunction

  // r mod g by six restoring steps, g non-zero
  function automatic logic [5:0] group_phase(input logic [5:0] r, input logic [5:0] g);
    logic [11:0] acc;
    logic [11:0] gs;
    acc = {6'd0, r};
    for (int k = 5; k >= 0; k--) begin
      gs = {6'd0, g} << k;
      if (acc >= gs) begin
        acc = acc - gs;
      end
    end
    return acc[5:0];
  endfunction

endpackage

// ===== src/number_to_counter_text_unit.sv =====
// Number to counter text. Push a 31-bit value and pop its text as 16-bit code units,
// one per transfer, with last on the final unit of each number; a zero in the alphabetic
// or roman styles yields a single result with empty_res set. Configuration (style,
// minimum decimal length, group size, separator) is sampled when a number is taken.
// The front converts a value into digits one by one (a reciprocal multiply, then a
// remainder); the back sends one character per cycle while its output is popped, after
// loading a job, except that a zero hundreds or tens digit of a roman number passes
// as a step with no output. A two-entry job queue lets both work at once, so the
// sustained cost per number is the larger of the two.
module number_to_counter_text_unit #(
  parameter int MAX_MIN_LENGTH = 32,
  parameter int QUEUE_DEPTH    = 2
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic [30:0] number_i,
  input  logic        pop,
  output logic        empty,
  output logic [15:0] character_o,
  output logic        last_o,
  output logic        empty_res_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i
);
  import nct_pkg::*;

  logic [2:0]  style_q;
  logic [5:0]  min_length_q, group_size_q;
  logic [15:0] group_sep_q;

  logic        fj_valid, fj_ready, bj_valid, bj_ready;
  job_t        fj_data, bj_data;

  assign cfg_ready_o = 1'b1;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      style_q      <= STYLE_DEC;
      min_length_q <= 6'd1;
      group_size_q <= 6'd0;
      group_sep_q  <= 16'd44;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_STYLE:      style_q      <= cfg_data_i[2:0];
        CFG_MIN_LENGTH: min_length_q <= cfg_data_i[5:0];
        CFG_GROUP_SIZE: group_size_q <= cfg_data_i[5:0];
        CFG_GROUP_SEP:  group_sep_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  nct_front #(
    .MaxMinLength(MAX_MIN_LENGTH)
  ) u_front (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .push              (push),
    .full              (full),
    .number_i          (number_i),
    .style_i           (style_q),
    .min_length_i      (min_length_q),
    .group_size_i      (group_size_q),
    .group_separator_i (group_sep_q),
    .job_valid_o       (fj_valid),
    .job_ready_i       (fj_ready),
    .job_o             (fj_data)
  );

  nct_queue #(
    .Depth(QUEUE_DEPTH)
  ) u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_valid_i (fj_valid),
    .wr_ready_o (fj_ready),
    .wr_data_i  (fj_data),
    .rd_valid_o (bj_valid),
    .rd_ready_i (bj_ready),
    .rd_data_o  (bj_data)
  );

  nct_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (bj_valid),
    .job_ready_o (bj_ready),
    .job_i       (bj_data),
    .pop         (pop),
    .empty       (empty),
    .character_o (character_o),
    .last_o      (last_o),
    .empty_res_o (empty_res_o)
  );

endmodule

// ===== src/nct_front.sv =====
module nct_front #(
  parameter int MaxMinLength = 32
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push,
  output logic                full,
  input  logic [30:0]         number_i,
  input  logic [2:0]          style_i,
  input  logic [5:0]          min_length_i,
  input  logic [5:0]          group_size_i,
  input  logic [15:0]         group_separator_i,
  output logic                job_valid_o,
  input  logic                job_ready_i,
  output nct_pkg::job_t       job_o
);
  import nct_pkg::*;

  localparam logic [2:0] F_IDLE = 3'd0;
  localparam logic [2:0] F_MUL  = 3'd1;
  localparam logic [2:0] F_DIV  = 3'd2;
  localparam logic [2:0] F_CALC = 3'd3;
  localparam logic [2:0] F_OUT  = 3'd4;

  localparam logic [5:0] MaxMl = 6'(MaxMinLength);

  logic [2:0]      state_q, state_d;
  logic [NumW-1:0] v_q, t_q;
  logic [62:0]     prod_q;
  logic            alpha_q;
  logic [5:0]      ml_q;
  job_t            job_q;

  logic            accept;
  logic            is_alpha, is_roman, roman_dec;
  logic [5:0]      ml_clamp;
  logic [NumW-1:0] t_d, quot, qd, rem;
  logic [5:0]      ndig_ext, total;

  assign accept      = push && (state_q == F_IDLE);
  assign full        = (state_q != F_IDLE);
  assign job_valid_o = (state_q == F_OUT);
  assign job_o       = job_q;

  // classify the incoming item
  assign is_alpha  = style_i inside {STYLE_ALPHA_LO, STYLE_ALPHA_UP};
  assign is_roman  = style_i inside {STYLE_ROMAN_LO, STYLE_ROMAN_UP};
  assign roman_dec = is_roman && (number_i >= ROMAN_LIMIT);
  assign ml_clamp  = (min_length_i == 6'd0) ? 6'd1 :
                     (min_length_i > MaxMl) ? MaxMl : min_length_i;

  // one digit: multiply by reciprocal, then remainder
  assign t_d  = v_q - {{(NumW-1){1'b0}}, alpha_q};
  assign quot = alpha_q ? NumW'(prod_q[62:36]) : NumW'(prod_q[62:35]);
  assign qd   = alpha_q ? (quot << 4) + (quot << 3) + (quot << 1) : (quot << 3) + (quot << 1);
  assign rem  = t_q - qd;

  // run length and separator phase
  assign ndig_ext = {2'd0, job_q.ndig};
  assign total    = (job_q.mode != MODE_DEC) ? ndig_ext :
                    (ndig_ext > ml_q) ? ndig_ext : ml_q;

  // sequencer
  always_comb begin
    state_d = state_q;
    case (state_q)
      F_IDLE: if (push) state_d = F_MUL;
      F_MUL:  state_d = (v_q == '0) ? F_CALC : F_DIV;
      F_DIV:  state_d = F_MUL;
      F_CALC: state_d = F_OUT;
      F_OUT:  if (job_ready_i) state_d = F_IDLE;
      default: state_d = F_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    case (state_q)
      F_IDLE: begin
        if (accept) begin
          v_q       <= number_i;
          alpha_q   <= is_alpha;
          ml_q      <= roman_dec ? 6'd1 : ml_clamp;
          job_q.dig <= '0;
          job_q.ndig <= 4'd0;
          job_q.upper <= (style_i == STYLE_ALPHA_UP) || (style_i == STYLE_ROMAN_UP);
          job_q.group <= (is_alpha || is_roman) ? 6'd0 : group_size_i;
          job_q.sep   <= group_separator_i;
          if (is_alpha) begin
            job_q.mode <= MODE_ALPHA;
          end else if (is_roman && !roman_dec) begin
            job_q.mode <= MODE_ROMAN;
          end else begin
            job_q.mode <= MODE_DEC;
          end
        end
      end
      F_MUL: begin
        t_q    <= t_d;
        prod_q <= 63'(t_d) * 63'(alpha_q ? RECIP26 : RECIP10);
      end
      F_DIV: begin
        job_q.dig[job_q.ndig] <= rem[4:0];
        job_q.ndig            <= job_q.ndig + 4'd1;
        v_q                   <= quot;
      end
      F_CALC: begin
        job_q.total <= total;
        job_q.phase <= (job_q.group != 6'd0) ? group_phase(total - 6'd1, job_q.group) : 6'd0;
      end
      default: ;
    endcase
  end

  // a 31-bit value has at most ten decimal digits
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == F_DIV) |-> (job_q.ndig < 4'(DigitsMax)))
    else $error("front: digit index out of range");

  // an offered job holds until it is taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (job_valid_o && !job_ready_i) |=> (job_valid_o && $stable(job_q)))
    else $error("front: job changed while waiting");

endmodule

// ===== src/nct_queue.sv =====
module nct_queue #(
  parameter int Depth = 2
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          wr_valid_i,
  output logic          wr_ready_o,
  input  nct_pkg::job_t wr_data_i,
  output logic          rd_valid_o,
  input  logic          rd_ready_i,
  output nct_pkg::job_t rd_data_o
);
  import nct_pkg::*;

  localparam int AW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CW = $clog2(Depth + 1);
  localparam logic [AW-1:0] LastIdx = AW'(Depth - 1);
  localparam logic [CW-1:0] DepthC  = CW'(Depth);

  job_t          mem_q [Depth];
  logic [AW-1:0] wptr_q, rptr_q;
  logic [CW-1:0] cnt_q;
  logic          wr_en, rd_en;

  assign wr_ready_o = (cnt_q != DepthC);
  assign rd_valid_o = (cnt_q != '0);
  assign rd_data_o  = mem_q[rptr_q];
  assign wr_en      = wr_valid_i && wr_ready_o;
  assign rd_en      = rd_valid_o && rd_ready_i;

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (wr_en) begin
        wptr_q <= (wptr_q == LastIdx) ? '0 : wptr_q + AW'(1);
      end
      if (rd_en) begin
        rptr_q <= (rptr_q == LastIdx) ? '0 : rptr_q + AW'(1);
      end
      if (wr_en && !rd_en) begin
        cnt_q <= cnt_q + CW'(1);
      end else if (rd_en && !wr_en) begin
        cnt_q <= cnt_q - CW'(1);
      end
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wptr_q] <= wr_data_i;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= DepthC)
    else $error("queue: fill count beyond depth");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (wr_en && !rd_en) |=> (cnt_q == $past(cnt_q) + CW'(1)))
    else $error("queue: write not counted");

endmodule

// ===== src/nct_back.sv =====
module nct_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          job_valid_i,
  output logic          job_ready_o,
  input  nct_pkg::job_t job_i,
  input  logic          pop,
  output logic          empty,
  output logic [15:0]   character_o,
  output logic          last_o,
  output logic          empty_res_o
);
  import nct_pkg::*;

  localparam logic [2:0] B_IDLE  = 3'd0;
  localparam logic [2:0] B_DIG   = 3'd1;
  localparam logic [2:0] B_SEP   = 3'd2;
  localparam logic [2:0] B_ALPHA = 3'd3;
  localparam logic [2:0] B_TH    = 3'd4;
  localparam logic [2:0] B_ROM   = 3'd5;
  localparam logic [2:0] B_EMPTY = 3'd6;

  logic [2:0]       st_q, st_d;
  job_t             job_q;
  logic [5:0]       pos_q, pos_d, ph_q, ph_d;
  logic [1:0]       cnt_q, cnt_d, p_q, p_d, k_q, k_d;
  logic             out_valid_q;
  logic [CharW-1:0] char_q;
  logic             last_q, emp_q;

  logic             adv, emit, e_last, e_empty;
  logic [CharW-1:0] e_char;
  logic [7:0]       shift, alpha_base;
  logic [3:0]       rdig;
  logic [2:0]       rlen;
  logic             rest0, lower0, sep_next, load;

  assign adv         = !out_valid_q || pop;
  assign job_ready_o = (st_q == B_IDLE);
  assign load        = job_valid_i && (st_q == B_IDLE);
  assign empty       = !out_valid_q;
  assign character_o = char_q;
  assign last_o      = last_q;
  assign empty_res_o = emp_q;

  assign shift      = job_q.upper ? 8'd32 : 8'd0;
  assign alpha_base = job_q.upper ? 8'h41 : 8'h61;
  assign rdig       = job_q.dig[{2'b00, p_q}][3:0];
  assign rlen       = shape_len(rdig);
  assign rest0      = (job_q.dig[2] == '0) && (job_q.dig[1] == '0) && (job_q.dig[0] == '0);
  assign lower0     = (p_q == 2'd2) ? ((job_q.dig[1] == '0) && (job_q.dig[0] == '0)) :
                      (p_q == 2'd1) ? (job_q.dig[0] == '0) : 1'b1;
  assign sep_next   = (job_q.group != 6'd0) && (pos_q != 6'd0) && (ph_q == 6'd0);

  // character sequencer
  always_comb begin
    st_d    = st_q;
    pos_d   = pos_q;
    ph_d    = ph_q;
    cnt_d   = cnt_q;
    p_d     = p_q;
    k_d     = k_q;
    emit    = 1'b0;
    e_char  = '0;
    e_last  = 1'b0;
    e_empty = 1'b0;
    case (st_q)
      B_IDLE: begin
        if (job_valid_i) begin
          case (job_i.mode)
            MODE_ALPHA: begin
              pos_d = {2'd0, job_i.ndig} - 6'd1;
              st_d  = (job_i.ndig == 4'd0) ? B_EMPTY : B_ALPHA;
            end
            MODE_ROMAN: begin
              cnt_d = job_i.dig[3][1:0];
              p_d   = 2'd2;
              k_d   = 2'd0;
              if (job_i.ndig == 4'd0) begin
                st_d = B_EMPTY;
              end else begin
                st_d = (job_i.dig[3] != '0) ? B_TH : B_ROM;
              end
            end
            default: begin
              pos_d = job_i.total - 6'd1;
              ph_d  = job_i.phase;
              st_d  = B_DIG;
            end
          endcase
        end
      end
      B_DIG: begin
        emit   = 1'b1;
        e_char = (pos_q < {2'd0, job_q.ndig}) ?
                 16'h0030 + 16'(job_q.dig[pos_q[3:0]]) : 16'h0030;
        e_last = (pos_q == 6'd0);
        if (adv) begin
          if (sep_next) begin
            st_d = B_SEP;
          end else if (pos_q == 6'd0) begin
            st_d = B_IDLE;
          end else begin
            pos_d = pos_q - 6'd1;
            ph_d  = (ph_q == 6'd0) ? job_q.group - 6'd1 : ph_q - 6'd1;
          end
        end
      end
      B_SEP: begin
        emit   = 1'b1;
        e_char = job_q.sep;
        if (adv) begin
          pos_d = pos_q - 6'd1;
          ph_d  = job_q.group - 6'd1;
          st_d  = B_DIG;
        end
      end
      B_ALPHA: begin
        emit   = 1'b1;
        e_char = 16'(alpha_base + 8'(job_q.dig[pos_q[3:0]]));
        e_last = (pos_q == 6'd0);
        if (adv) begin
          if (pos_q == 6'd0) begin
            st_d = B_IDLE;
          end else begin
            pos_d = pos_q - 6'd1;
          end
        end
      end
      B_TH: begin
        emit   = 1'b1;
        e_char = 16'(8'h6D - shift);
        e_last = (cnt_q == 2'd1) && rest0;
        if (adv) begin
          if (cnt_q == 2'd1) begin
            st_d = rest0 ? B_IDLE : B_ROM;
          end else begin
            cnt_d = cnt_q - 2'd1;
          end
        end
      end
      B_ROM: begin
        if (rlen == 3'd0) begin
          // digit with no letters: move on without output
          if (p_q == 2'd0) begin
            st_d = B_IDLE;
          end else begin
            p_d = p_q - 2'd1;
          end
        end else begin
          emit   = 1'b1;
          e_char = 16'(roman_char(p_q, shape_sym(rdig, k_q)) - shift);
          e_last = ({1'b0, k_q} == rlen - 3'd1) && lower0;
          if (adv) begin
            if ({1'b0, k_q} == rlen - 3'd1) begin
              k_d = 2'd0;
              if (lower0) begin
                st_d = B_IDLE;
              end else begin
                p_d = p_q - 2'd1;
              end
            end else begin
              k_d = k_q + 2'd1;
            end
          end
        end
      end
      B_EMPTY: begin
        emit    = 1'b1;
        e_last  = 1'b1;
        e_empty = 1'b1;
        if (adv) st_d = B_IDLE;
      end
      default: st_d = B_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= B_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      st_q <= st_d;
      if (emit && adv) begin
        out_valid_q <= 1'b1;
      end else if (pop) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // counters and output register
  always_ff @(posedge clk_i) begin
    pos_q <= pos_d;
    ph_q  <= ph_d;
    cnt_q <= cnt_d;
    p_q   <= p_d;
    k_q   <= k_d;
    if (load) begin
      job_q <= job_i;
    end
    if (emit && adv) begin
      char_q <= e_char;
      last_q <= e_last;
      emp_q  <= e_empty;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && emp_q) |-> (last_q && (char_q == '0)))
    else $error("back: empty result not flagged last");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((st_q == B_DIG) || (st_q == B_SEP)) |-> (job_q.mode == MODE_DEC))
    else $error("back: decimal state on a non-decimal job");

endmodule
